// ===== sv/iambic_keyer_macros.svh =====
// assertion macros for the keyer checker
`ifndef IAMBIC_KEYER_MACROS_SVH
`define IAMBIC_KEYER_MACROS_SVH

// same-cycle implication, clocked on aclk, off during reset
`define IAK_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("keyer check failed");

// next-cycle implication, clocked on aclk, off during reset
`define IAK_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("keyer check failed");

`endif

// ===== sv/iak_pkg.sv =====
package iak_pkg;

    localparam int DIT_W   = 16;
    localparam int RATIO_W = 3;
    localparam int TICKS_W = DIT_W + RATIO_W;
    localparam int SQ_W    = 3;

    localparam logic [DIT_W-1:0]   DIT_TICKS_RESET = 16'd200;
    localparam logic [RATIO_W-1:0] DAH_RATIO_RESET = 3'd3;

    // configuration register indexes
    localparam logic REG_DIT_TICKS = 1'b0;
    localparam logic REG_DAH_RATIO = 1'b1;

    // request types
    localparam logic REQ_TICK   = 1'b0;
    localparam logic REQ_PADDLE = 1'b1;

    // paddle sides
    localparam logic SIDE_DIT = 1'b0;
    localparam logic SIDE_DAH = 1'b1;

    // squeeze register codes
    localparam logic [SQ_W-1:0] SQ_NONE   = 3'd0;
    localparam logic [SQ_W-1:0] SQ_DIT    = 3'd1;
    localparam logic [SQ_W-1:0] SQ_DAH    = 3'd2;
    localparam logic [SQ_W-1:0] SQ_DITDAH = 3'd3;
    localparam logic [SQ_W-1:0] SQ_DAHDIT = 3'd4;

    typedef struct packed {
        logic [DIT_W-1:0]   dit_len;
        logic [TICKS_W-1:0] dah_len;
    } cfg_t;

    typedef struct packed {
        logic req_type;
        logic paddle_side;
        logic pressed;
    } item_t;

endpackage

// ===== sv/iak_cfg.sv =====
module iak_cfg import iak_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic             cfg_index,
    input  logic [DIT_W-1:0] cfg_data,
    output cfg_t             cfg
);

    logic [DIT_W-1:0]   dit_ticks_reg;
    logic [RATIO_W-1:0] dah_ratio_reg;
    logic [DIT_W-1:0]   dit_len_reg;
    logic [TICKS_W-1:0] dah_len_reg;
    logic [DIT_W-1:0]   dit_len_next;
    logic [RATIO_W-1:0] ratio_eff;
    logic [TICKS_W-1:0] dah_len_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dit_ticks_reg <= DIT_TICKS_RESET;
            dah_ratio_reg <= DAH_RATIO_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_DIT_TICKS: dit_ticks_reg <= cfg_data;
                REG_DAH_RATIO: dah_ratio_reg <= cfg_data[RATIO_W-1:0];
                default: ;
            endcase
        end
    end

    // zero values act as one
    assign dit_len_next = (dit_ticks_reg == '0) ? DIT_W'(1) : dit_ticks_reg;
    assign ratio_eff    = (dah_ratio_reg == '0) ? RATIO_W'(1) : dah_ratio_reg;
    assign dah_len_next = TICKS_W'(ratio_eff) * TICKS_W'(dit_len_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dit_len_reg <= DIT_TICKS_RESET;
            dah_len_reg <= TICKS_W'(DIT_TICKS_RESET) * TICKS_W'(DAH_RATIO_RESET);
        end else begin
            dit_len_reg <= dit_len_next;
            dah_len_reg <= dah_len_next;
        end
    end

    assign cfg.dit_len = dit_len_reg;
    assign cfg.dah_len = dah_len_reg;

endmodule

// ===== sv/iak_engine.sv =====
module iak_engine import iak_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            step_en,
    input  item_t           item,
    input  cfg_t            cfg,
    output logic            key_on,
    output logic [SQ_W-1:0] paddle_state
);

    logic [SQ_W-1:0]    squeeze_reg, squeeze_next;
    logic               alt_reg, alt_next;
    logic               tone_reg, tone_next;
    logic [TICKS_W-1:0] ticks_reg, ticks_next;
    logic [TICKS_W-1:0] ticks_load;
    logic [TICKS_W-1:0] dit_ext;

    assign dit_ext = TICKS_W'(cfg.dit_len);

    always_comb begin
        squeeze_next = squeeze_reg;
        alt_next     = alt_reg;
        tone_next    = tone_reg;
        ticks_next   = ticks_reg;
        ticks_load   = ticks_reg;
        if (step_en) begin
            if (item.req_type == REQ_PADDLE) begin
                if (item.pressed) begin
                    if (item.paddle_side == SIDE_DIT) begin
                        if (squeeze_reg == SQ_NONE) squeeze_next = SQ_DIT;
                        else if (squeeze_reg == SQ_DAH) squeeze_next = SQ_DAHDIT;
                    end else begin
                        if (squeeze_reg == SQ_NONE) squeeze_next = SQ_DAH;
                        else if (squeeze_reg == SQ_DIT) squeeze_next = SQ_DITDAH;
                    end
                end else begin
                    if (item.paddle_side == SIDE_DIT) begin
                        if (squeeze_reg == SQ_DITDAH || squeeze_reg == SQ_DAHDIT)
                            squeeze_next = SQ_DAH;
                        else if (squeeze_reg == SQ_DIT) squeeze_next = SQ_NONE;
                    end else begin
                        if (squeeze_reg == SQ_DITDAH || squeeze_reg == SQ_DAHDIT)
                            squeeze_next = SQ_DIT;
                        else if (squeeze_reg == SQ_DAH) squeeze_next = SQ_NONE;
                    end
                end
            end else begin
                // element boundary
                if (ticks_reg == '0) begin
                    if (tone_reg) begin
                        tone_next  = 1'b0;
                        ticks_load = dit_ext;
                    end else begin
                        tone_next = 1'b1;
                        unique case (squeeze_reg)
                            SQ_DIT: begin
                                ticks_load = dit_ext;
                                alt_next   = 1'b1;
                            end
                            SQ_DAH: begin
                                ticks_load = cfg.dah_len;
                                alt_next   = 1'b1;
                            end
                            SQ_DITDAH: begin
                                ticks_load = alt_reg ? cfg.dah_len : dit_ext;
                                alt_next   = !alt_reg;
                            end
                            SQ_DAHDIT: begin
                                ticks_load = alt_reg ? dit_ext : cfg.dah_len;
                                alt_next   = !alt_reg;
                            end
                            default: begin
                                tone_next  = 1'b0;
                                ticks_load = dit_ext;
                                alt_next   = 1'b1;
                            end
                        endcase
                    end
                end
                ticks_next = ticks_load - TICKS_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            squeeze_reg <= SQ_NONE;
            alt_reg     <= 1'b1;
            tone_reg    <= 1'b0;
            ticks_reg   <= '0;
        end else begin
            squeeze_reg <= squeeze_next;
            alt_reg     <= alt_next;
            tone_reg    <= tone_next;
            ticks_reg   <= ticks_next;
        end
    end

    assign key_on       = tone_next;
    assign paddle_state = squeeze_next;

endmodule

// ===== sv/iambic_keyer.sv =====
// Iambic keyer. Each input transfer is either a time tick or a paddle press/release;
// each yields exactly one result transfer carrying the key level and the paddle
// squeeze state (0 none, 1 dit, 2 dah, 3 dit-then-dah, 4 dah-then-dit) as it stands
// after that item. One item is taken every clock cycle unless a stalled result holds the
// flow: the input register feeds a combinational state update that loads the result
// register; throughput is limited only by the result side's ready. Configuration writes
// (index 0 dit_ticks, index 1 dah_ratio, zero treated as one) apply to every input
// transfer accepted after the write edge, with no idle cycle needed; the registered
// dah length is ready by the time such an item reaches the state update. New values
// take effect at the next element boundary.
module iambic_keyer import iak_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic             s_req_type,
    input  logic             s_paddle_side,
    input  logic             s_pressed,
    output logic             m_valid,
    input  logic             m_ready,
    output logic             m_key_on,
    output logic [SQ_W-1:0]  m_paddle_state,
    input  logic             cfg_wr_en,
    input  logic             cfg_index,
    input  logic [DIT_W-1:0] cfg_data
);

    cfg_t            cfg;
    item_t           item_reg;
    logic            in_valid_reg;
    logic            out_valid_reg;
    logic            key_on_reg;
    logic [SQ_W-1:0] paddle_state_reg;
    logic            advance;
    logic            step_en;
    logic            key_on_next;
    logic [SQ_W-1:0] paddle_state_next;

    assign advance = !out_valid_reg || m_ready;
    assign step_en = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    iak_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    iak_engine u_engine (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step_en      (step_en),
        .item         (item_reg),
        .cfg          (cfg),
        .key_on       (key_on_next),
        .paddle_state (paddle_state_next)
    );

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.req_type    <= s_req_type;
            item_reg.paddle_side <= s_paddle_side;
            item_reg.pressed     <= s_pressed;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            key_on_reg       <= key_on_next;
            paddle_state_reg <= paddle_state_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_key_on       = key_on_reg;
    assign m_paddle_state = paddle_state_reg;

endmodule

// ===== sv/iak_checker.sv =====
`include "iambic_keyer_macros.svh"

module iak_checker import iak_pkg::*; (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input logic             m_valid,
    input logic             m_ready,
    input logic             m_key_on,
    input logic [SQ_W-1:0]  m_paddle_state
);

    // squeeze state code stays in range
    `IAK_ASSERT_SAME(a_state_range, m_valid, m_paddle_state <= SQ_DAHDIT)

    // an empty result side never blocks the input
    `IAK_ASSERT_SAME(a_ready_when_empty, !m_valid, s_ready)

    // a waiting input transfer stays offered
    `IAK_ASSERT_NEXT(a_valid_held, s_valid && !s_ready, s_valid)

    // stalled result holds
    `IAK_ASSERT_NEXT(a_stall_hold, m_valid && !m_ready,
        m_valid && $stable(m_key_on) && $stable(m_paddle_state))

endmodule

bind iambic_keyer iak_checker u_iak_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_key_on       (m_key_on),
    .m_paddle_state (m_paddle_state)
);

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import iak_pkg::*;

    localparam logic PUSH = 1'b1;
    localparam logic LIFT = 1'b0;

    localparam int DIR_ROWS       = 24;
    localparam int FIRST_TICK_ROW = 11;
    localparam int N_PHASES       = 7;
    localparam int CALM_AFTER     = 850;
    localparam int HOLD_AT        = 300;
    localparam int HOLD_CYCLES    = 80;

    typedef struct packed {
        logic            key;
        logic [SQ_W-1:0] st;
    } key_result_t;

    typedef struct packed {
        logic        req;
        logic        side;
        logic        press;
        logic        typed;
        key_result_t want;
    } step_row_t;

    // squeeze walk at reset settings, then ticks once the dit is one tick long
    localparam step_row_t SCRIPT [DIR_ROWS] = '{
        '{REQ_PADDLE, SIDE_DIT, PUSH, 1'b1, '{1'b0, SQ_DIT}},
        '{REQ_PADDLE, SIDE_DIT, PUSH, 1'b1, '{1'b0, SQ_DIT}},
        '{REQ_PADDLE, SIDE_DAH, PUSH, 1'b1, '{1'b0, SQ_DITDAH}},
        '{REQ_PADDLE, SIDE_DAH, LIFT, 1'b1, '{1'b0, SQ_DIT}},
        '{REQ_PADDLE, SIDE_DAH, LIFT, 1'b1, '{1'b0, SQ_DIT}},
        '{REQ_PADDLE, SIDE_DAH, PUSH, 1'b1, '{1'b0, SQ_DITDAH}},
        '{REQ_PADDLE, SIDE_DIT, LIFT, 1'b1, '{1'b0, SQ_DAH}},
        '{REQ_PADDLE, SIDE_DIT, PUSH, 1'b1, '{1'b0, SQ_DAHDIT}},
        '{REQ_PADDLE, SIDE_DAH, LIFT, 1'b1, '{1'b0, SQ_DIT}},
        '{REQ_PADDLE, SIDE_DIT, LIFT, 1'b1, '{1'b0, SQ_NONE}},
        '{REQ_PADDLE, SIDE_DIT, LIFT, 1'b1, '{1'b0, SQ_NONE}},
        '{REQ_TICK,   SIDE_DIT, LIFT, 1'b0, '{1'b0, SQ_NONE}},
        '{REQ_PADDLE, SIDE_DAH, PUSH, 1'b0, '{1'b0, SQ_NONE}},
        '{REQ_PADDLE, SIDE_DIT, PUSH, 1'b0, '{1'b0, SQ_NONE}},
        '{REQ_TICK,   SIDE_DAH, PUSH, 1'b0, '{1'b0, SQ_NONE}},
        '{REQ_TICK,   SIDE_DIT, LIFT, 1'b0, '{1'b0, SQ_NONE}},
        '{REQ_TICK,   SIDE_DAH, LIFT, 1'b0, '{1'b0, SQ_NONE}},
        '{REQ_TICK,   SIDE_DIT, PUSH, 1'b0, '{1'b0, SQ_NONE}},
        '{REQ_TICK,   SIDE_DIT, LIFT, 1'b0, '{1'b0, SQ_NONE}},
        '{REQ_TICK,   SIDE_DIT, LIFT, 1'b0, '{1'b0, SQ_NONE}},
        '{REQ_PADDLE, SIDE_DAH, LIFT, 1'b0, '{1'b0, SQ_NONE}},
        '{REQ_TICK,   SIDE_DIT, LIFT, 1'b0, '{1'b0, SQ_NONE}},
        '{REQ_PADDLE, SIDE_DIT, LIFT, 1'b0, '{1'b0, SQ_NONE}},
        '{REQ_TICK,   SIDE_DIT, LIFT, 1'b0, '{1'b0, SQ_NONE}}
    };

    localparam logic [DIT_W-1:0] PH_DIT [N_PHASES] =
        '{16'd0, 16'd1, 16'd3, 16'd2, 16'd5, 16'd1, 16'hFFFF};
    localparam logic [RATIO_W-1:0] PH_RATIO [N_PHASES] =
        '{3'd0, 3'd7, 3'd3, 3'd5, 3'd2, 3'd1, 3'd7};
    localparam int PH_ITEMS [N_PHASES] = '{150, 150, 150, 150, 150, 150, 30};

    logic             aclk;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    logic             s_req_type;
    logic             s_paddle_side;
    logic             s_pressed;
    logic             m_valid;
    logic             m_ready;
    logic             m_key_on;
    logic [SQ_W-1:0]  m_paddle_state;
    logic             cfg_wr_en;
    logic             cfg_index;
    logic [DIT_W-1:0] cfg_data;

    key_result_t pending [$];
    int          errors      = 0;
    int          sent        = 0;
    int          ticks_sent  = 0;
    int          results     = 0;
    bit          calm        = 1'b0;
    bit          hold_done   = 1'b0;
    logic [4:0]  seen_states = '0;

    // keyer state as predicted
    logic [SQ_W-1:0]    p_squeeze;
    logic               p_alt;
    logic               p_tone;
    logic [TICKS_W-1:0] p_left;
    logic [DIT_W-1:0]   p_dit;
    logic [RATIO_W-1:0] p_ratio;

    iambic_keyer dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_paddle_side  (s_paddle_side),
        .s_pressed      (s_pressed),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_key_on       (m_key_on),
        .m_paddle_state (m_paddle_state),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #4_000_000;
        $display("timeout with %0d transfers outstanding", pending.size());
        $display("FAILURE");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        errors++;
    endtask

    function automatic logic [TICKS_W-1:0] dit_span();
        return (p_dit == '0) ? TICKS_W'(1) : TICKS_W'(p_dit);
    endfunction

    function automatic logic [TICKS_W-1:0] dah_span();
        logic [TICKS_W-1:0] mult;
        mult = (p_ratio == '0) ? TICKS_W'(1) : TICKS_W'(p_ratio);
        return mult * dit_span();
    endfunction

    task automatic keyer_step(input logic req, input logic side, input logic press,
                              output key_result_t r);
        if (req == REQ_PADDLE) begin
            if (press) begin
                if (side == SIDE_DIT) begin
                    if (p_squeeze == SQ_NONE) p_squeeze = SQ_DIT;
                    else if (p_squeeze == SQ_DAH) p_squeeze = SQ_DAHDIT;
                end else begin
                    if (p_squeeze == SQ_NONE) p_squeeze = SQ_DAH;
                    else if (p_squeeze == SQ_DIT) p_squeeze = SQ_DITDAH;
                end
            end else begin
                if (side == SIDE_DIT) begin
                    if (p_squeeze == SQ_DITDAH || p_squeeze == SQ_DAHDIT) p_squeeze = SQ_DAH;
                    else if (p_squeeze == SQ_DIT) p_squeeze = SQ_NONE;
                end else begin
                    if (p_squeeze == SQ_DITDAH || p_squeeze == SQ_DAHDIT) p_squeeze = SQ_DIT;
                    else if (p_squeeze == SQ_DAH) p_squeeze = SQ_NONE;
                end
            end
        end else begin
            if (p_left == '0) begin
                if (p_tone) begin
                    p_tone = 1'b0;
                    p_left = dit_span();
                end else begin
                    p_tone = 1'b1;
                    case (p_squeeze)
                        SQ_DIT: begin
                            p_left = dit_span();
                            p_alt  = 1'b1;
                        end
                        SQ_DAH: begin
                            p_left = dah_span();
                            p_alt  = 1'b1;
                        end
                        SQ_DITDAH: begin
                            p_left = p_alt ? dah_span() : dit_span();
                            p_alt  = ~p_alt;
                        end
                        SQ_DAHDIT: begin
                            p_left = p_alt ? dit_span() : dah_span();
                            p_alt  = ~p_alt;
                        end
                        default: begin
                            p_tone = 1'b0;
                            p_alt  = 1'b1;
                            p_left = dit_span();
                        end
                    endcase
                end
            end
            p_left = p_left - 1'b1;
        end
        r.key = p_tone;
        r.st  = p_squeeze;
    endtask

    // called at a falling edge; leaves valid high unless a gap follows
    task automatic send_item(input logic req, input logic side, input logic press,
                             input logic typed, input key_result_t want);
        key_result_t r;
        s_valid       <= 1'b1;
        s_req_type    <= req;
        s_paddle_side <= side;
        s_pressed     <= press;
        do @(posedge aclk); while (!s_ready);
        keyer_step(req, side, press, r);
        pending.push_back(typed ? want : r);
        sent++;
        if (req == REQ_TICK) ticks_sent++;
        if (sent >= CALM_AFTER) calm = 1'b1;
        @(negedge aclk);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge aclk);
        end
    endtask

    task automatic set_config(input logic [DIT_W-1:0] dit, input logic [RATIO_W-1:0] ratio);
        logic [DIT_W-1:0] word;
        s_valid <= 1'b0;
        while (pending.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_DIT_TICKS;
        cfg_data  <= dit;
        @(negedge aclk);
        // upper bits of the ratio word are don't-care
        word = DIT_W'($urandom);
        word[RATIO_W-1:0] = ratio;
        cfg_index <= REG_DAH_RATIO;
        cfg_data  <= word;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        p_dit     = dit;
        p_ratio   = word[RATIO_W-1:0];
        repeat (2) @(negedge aclk);
    endtask

    always @(posedge aclk) begin
        key_result_t e;
        if (aresetn && m_valid && m_ready) begin
            results++;
            if (m_paddle_state < 5) seen_states[m_paddle_state] = 1'b1;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("unexpected transfer key_on=%0d paddle_state=%0d",
                                          m_key_on, m_paddle_state));
            end else begin
                e = pending.pop_front();
                if (m_key_on !== e.key)
                    report_mismatch($sformatf("result %0d key_on got %b want %b",
                                              results, m_key_on, e.key));
                if (m_paddle_state !== e.st)
                    report_mismatch($sformatf("result %0d paddle_state got %0d want %0d",
                                              results, m_paddle_state, e.st));
            end
        end
    end

    // result side: short random stalls plus one long hold-off
    initial begin
        m_ready <= 1'b0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (!hold_done && !calm && results >= HOLD_AT) begin
                m_ready <= 1'b0;
                for (int k = 0; k < HOLD_CYCLES; k++) @(negedge aclk);
                hold_done = 1'b1;
                m_ready <= 1'b1;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        logic side;
        logic press;
        logic held;
        aresetn       <= 1'b0;
        s_valid       <= 1'b0;
        s_req_type    <= REQ_TICK;
        s_paddle_side <= SIDE_DIT;
        s_pressed     <= LIFT;
        cfg_wr_en     <= 1'b0;
        cfg_index     <= REG_DIT_TICKS;
        cfg_data      <= '0;
        p_squeeze = SQ_NONE;
        p_alt     = 1'b1;
        p_tone    = 1'b0;
        p_left    = '0;
        p_dit     = DIT_TICKS_RESET;
        p_ratio   = DAH_RATIO_RESET;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            // zero dit and zero ratio both act as one
            if (i == FIRST_TICK_ROW) set_config('0, '0);
            send_item(SCRIPT[i].req, SCRIPT[i].side, SCRIPT[i].press,
                      SCRIPT[i].typed, SCRIPT[i].want);
        end

        for (int p = 0; p < N_PHASES; p++) begin
            set_config(PH_DIT[p], PH_RATIO[p]);
            for (int n = 0; n < PH_ITEMS[p]; n++) begin
                if ($urandom_range(0, 3) != 0) begin
                    send_item(REQ_TICK, 1'($urandom), 1'($urandom), 1'b0, '0);
                end else begin
                    side = 1'($urandom);
                    held = (p_squeeze == SQ_DITDAH) || (p_squeeze == SQ_DAHDIT) ||
                           (p_squeeze == ((side == SIDE_DIT) ? SQ_DIT : SQ_DAH));
                    press = ($urandom_range(0, 4) != 0) ? ~held : 1'($urandom);
                    send_item(REQ_PADDLE, side, press, 1'b0, '0);
                end
            end
        end
        s_valid <= 1'b0;

        while (pending.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("%0d items sent (%0d ticks, %0d paddle transfers), %0d results checked",
                 sent, ticks_sent, sent - ticks_sent, results);
        $display("dit lengths 1 to 65535, dah ratios 0 to 7, squeeze states seen %b",
                 seen_states);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== iambic_keyer.f =====
+incdir+sv
sv/iak_pkg.sv
sv/iak_cfg.sv
sv/iak_engine.sv
sv/iambic_keyer.sv
sv/iak_checker.sv
tb/tb.sv
